/* design/msga_pkg.sv */
// ----------------------------------------------------------------------------
// msga_pkg: shared types and constants for the gas alarm latch
// station count, command codes, register reset value and the scan result
// ----------------------------------------------------------------------------
package msga_pkg;

  localparam int STATION_COUNT = 10;
  localparam int ST_W          = 4;
  localparam int DIV_W         = 8;

  typedef logic [ST_W-1:0]          station_t;
  typedef logic [STATION_COUNT-1:0] marks_t;
  typedef logic [DIV_W-1:0]         div_t;

  localparam station_t LAST_STATION = station_t'(STATION_COUNT - 1);

  localparam logic [1:0] CMD_SAMPLE = 2'd0;
  localparam logic [1:0] CMD_MUTE   = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam div_t DIV_RESET = div_t'(100);

  // status of the station scan unit
  typedef struct packed {
    logic     done;
    logic     found;
    station_t idx;
  } scan_res_t;

endpackage

/* design/msga_scan.sv */
// ----------------------------------------------------------------------------
// msga_scan: station scan unit
// walks the candidate vector one station per cycle from station zero and
// stops at the first set bit or after the last station
// ----------------------------------------------------------------------------
module msga_scan
  import msga_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      scan_go,
  input  marks_t    cand,
  output scan_res_t res
);

  logic     active_r, active_nxt;
  station_t idx_r, idx_nxt;
  logic     hit;

  always_comb begin
    hit       = cand[idx_r];
    res.done  = active_r && (hit || (idx_r == LAST_STATION));
    res.found = active_r && hit;
    res.idx   = idx_r;
  end

  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    if (scan_go) begin
      active_nxt = 1'b1;
      idx_nxt    = '0;
    end else if (res.done) begin
      active_nxt = 1'b0;
    end else if (active_r) begin
      idx_nxt = idx_r + station_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
    end
  end

endmodule

/* design/multi_station_gas_alarm_latch_core.sv */
// ----------------------------------------------------------------------------
// multi_station_gas_alarm_latch_core: alarm panel for gas detector stations
// keeps per-station fault, alarm, latch and link marks, mutes alarms and
// steps a rotating fault display on timer ticks
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the result is out. A sample, a timer tick or an unused command passes
// through the execute and report states before the out_valid strobe.
// A mute press runs the station scan unit, which looks at one station per
// cycle from station zero up to the lowest station with alarm and latch set,
// or up to the last station when there is nothing to mute (execute, scan,
// report). The result is on the out_ ports for exactly one cycle
// with out_valid high, and the receiver cannot stall it; busy is already low
// in that cycle, so the next request can be taken at the same edge.
// alarm_led and relays_on reflect the marks after the request has been
// applied. The display divider register may be written at any edge with
// cfg_write_en high, but only while no request is in progress.
// ----------------------------------------------------------------------------
module multi_station_gas_alarm_latch_core
  import msga_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  // request channel
  input  logic     start,
  output logic     busy,
  input  logic [1:0] in_command,
  input  station_t in_station,
  input  logic     in_link_paired,
  input  logic     in_gas_clear,
  // configuration
  input  logic     cfg_write_en,
  input  div_t     cfg_write_data,
  // result channel
  output logic     out_valid,
  output logic     out_alarm_led,
  output logic     out_relays_on,
  output logic     out_new_fault,
  output logic     out_muted,
  output station_t out_muted_station,
  output logic     out_show_fault,
  output station_t out_shown_station
);

  // sequencer codes
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_REPORT = 2'd3;

  logic [1:0] state_r, state_nxt;

  // captured request
  logic [1:0] cmd_r, cmd_nxt;
  station_t   station_r, station_nxt;
  logic       paired_r, paired_nxt;
  logic       clear_r, clear_nxt;

  // station marks
  marks_t fault_r, fault_nxt;
  marks_t alarm_r, alarm_nxt;
  marks_t latched_r, latched_nxt;
  marks_t link_r, link_nxt;

  // display rotation
  div_t     tick_r, tick_nxt;
  div_t     tick_inc;
  station_t ptr_r, ptr_nxt;
  div_t     divider_r, divider_nxt;

  // result registers
  logic     valid_r, valid_nxt;
  logic     led_r, led_nxt;
  logic     relays_r, relays_nxt;
  logic     new_fault_r, new_fault_nxt;
  logic     muted_r, muted_nxt;
  station_t muted_st_r, muted_st_nxt;
  logic     show_r, show_nxt;
  station_t shown_r, shown_nxt;

  logic      accept;
  logic      in_range;
  logic      scan_go;
  scan_res_t scan_res;

  assign accept   = start && !busy;
  assign busy     = (state_r != S_IDLE);
  assign in_range = ({1'b0, station_r} < (ST_W + 1)'(STATION_COUNT));
  assign tick_inc = tick_r + div_t'(1);
  assign scan_go  = (state_r == S_EXEC) && (cmd_r == CMD_MUTE);

  // mute candidates: alarm set and latched
  msga_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .scan_go (scan_go),
    .cand    (alarm_r & latched_r),
    .res     (scan_res)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    station_nxt   = station_r;
    paired_nxt    = paired_r;
    clear_nxt     = clear_r;
    fault_nxt     = fault_r;
    alarm_nxt     = alarm_r;
    latched_nxt   = latched_r;
    link_nxt      = link_r;
    tick_nxt      = tick_r;
    ptr_nxt       = ptr_r;
    divider_nxt   = cfg_write_en ? cfg_write_data : divider_r;
    valid_nxt     = 1'b0;
    led_nxt       = led_r;
    relays_nxt    = relays_r;
    new_fault_nxt = new_fault_r;
    muted_nxt     = muted_r;
    muted_st_nxt  = muted_st_r;
    show_nxt      = show_r;
    shown_nxt     = shown_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt     = in_command;
          station_nxt = in_station;
          paired_nxt  = in_link_paired;
          clear_nxt   = in_gas_clear;
          state_nxt   = S_EXEC;
        end
      end

      S_EXEC: begin
        // fields that carry no meaning for this request read zero
        new_fault_nxt = 1'b0;
        muted_nxt     = 1'b0;
        muted_st_nxt  = '0;
        show_nxt      = 1'b0;
        shown_nxt     = '0;
        state_nxt     = S_REPORT;
        case (cmd_r)
          CMD_SAMPLE: begin
            if (in_range) begin
              link_nxt[station_r] = paired_r;
              // fault and alarm marks of latched stations take no new samples until reset
              if (paired_r && !latched_r[station_r]) begin
                fault_nxt[station_r] = !clear_r;
                alarm_nxt[station_r] = !clear_r;
                if (!clear_r) begin
                  latched_nxt[station_r] = 1'b1;
                  new_fault_nxt          = 1'b1;
                end
              end
            end
          end
          CMD_MUTE: begin
            state_nxt = S_SCAN;
          end
          CMD_TICK: begin
            tick_nxt = tick_inc;
            // a divider of zero wraps the counter, so it acts as 256
            if (tick_inc == divider_r) begin
              show_nxt  = fault_r[ptr_r];
              shown_nxt = ptr_r;
              ptr_nxt   = (ptr_r == LAST_STATION) ? '0 : ptr_r + station_t'(1);
              tick_nxt  = '0;
            end
          end
          default: begin
            // unused command only reports the lamp and relay status
          end
        endcase
      end

      S_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.found) begin
            alarm_nxt[scan_res.idx] = 1'b0;
            muted_nxt               = 1'b1;
            muted_st_nxt            = scan_res.idx;
          end
          state_nxt = S_REPORT;
        end
      end

      S_REPORT: begin
        led_nxt    = |alarm_r;
        relays_nxt = ~|fault_r;
        valid_nxt  = 1'b1;
        state_nxt  = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fault_r     <= '0;
      alarm_r     <= '0;
      latched_r   <= '0;
      link_r      <= '0;
      tick_r      <= '0;
      ptr_r       <= '0;
      divider_r   <= DIV_RESET;
      valid_r     <= 1'b0;
      led_r       <= 1'b0;
      relays_r    <= 1'b0;
      new_fault_r <= 1'b0;
      muted_r     <= 1'b0;
      muted_st_r  <= '0;
      show_r      <= 1'b0;
      shown_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      fault_r     <= fault_nxt;
      alarm_r     <= alarm_nxt;
      latched_r   <= latched_nxt;
      link_r      <= link_nxt;
      tick_r      <= tick_nxt;
      ptr_r       <= ptr_nxt;
      divider_r   <= divider_nxt;
      valid_r     <= valid_nxt;
      led_r       <= led_nxt;
      relays_r    <= relays_nxt;
      new_fault_r <= new_fault_nxt;
      muted_r     <= muted_nxt;
      muted_st_r  <= muted_st_nxt;
      show_r      <= show_nxt;
      shown_r     <= shown_nxt;
    end
  end

  // captured request, no reset needed
  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    station_r <= station_nxt;
    paired_r  <= paired_nxt;
    clear_r   <= clear_nxt;
  end

  assign out_valid         = valid_r;
  assign out_alarm_led     = led_r;
  assign out_relays_on     = relays_r;
  assign out_new_fault     = new_fault_r;
  assign out_muted         = muted_r;
  assign out_muted_station = muted_st_r;
  assign out_show_fault    = show_r;
  assign out_shown_station = shown_r;

  // each request yields one strobe, never two in a row
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$past(out_valid))
    else $error("result strobe held for two cycles");

  // an accepted request keeps the block busy at the next edge
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("block not busy after accepting a request");

  // a latched station never unlatches outside reset
  a_latch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ((latched_r & ~latched_nxt) == '0))
    else $error("latched station released");

  // a mute only ever clears an alarm that was latched
  a_mute_latched: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_res.found) |-> latched_r[scan_res.idx])
    else $error("muted a station that was not latched");

  // the scan only runs while the sequencer waits on it
  a_scan_owned: assert property (@(posedge clk) disable iff (!rst_n)
    scan_res.done |-> (state_r == S_SCAN))
    else $error("scan finished outside the scan state");

endmodule
